// File: src/rshf_pkg.sv
// package for the range scan hole-fill smoother
// holds widths, tap weights and the controller/datapath command and status types
// no dependencies
package rshf_pkg;

  localparam int unsigned DistW    = 16;
  localparam int unsigned AccW     = 20;
  localparam int unsigned WsumW    = 5;
  localparam int unsigned WinDepth = 4;
  localparam int unsigned SnapLen  = WinDepth + 1;
  localparam int unsigned DivSteps = AccW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [DistW-1:0]   MaxValidRst = 16'd5000;
  localparam logic [2:0]         LastTap     = 3'd4;
  localparam logic [2:0]         FirstCenter = 3'd2;
  localparam logic [2:0]         LastCenter  = 3'd4;
  localparam logic [DivCntW-1:0] LastDivStep = DivCntW'(DivSteps - 1);

  // binomial tap weights 1,4,6,4,1
  function automatic logic [2:0] tap_weight(input logic [2:0] tap);
    logic [2:0] w;
    unique case (tap)
      3'd0:    w = 3'd1;
      3'd1:    w = 3'd4;
      3'd2:    w = 3'd6;
      3'd3:    w = 3'd4;
      3'd4:    w = 3'd1;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

  // commands from controller to datapath
  typedef struct packed {
    logic       load;      // capture accepted ray into snapshot and window
    logic       clr;       // clear accumulators for a new center
    logic       tap_en;    // accumulate one tap
    logic       div_init;  // load divider from accumulators
    logic       div_en;    // one restoring divide step
    logic       push;      // write result into output register
    logic [2:0] center;    // snapshot position of the ray being filtered
    logic [2:0] tap;       // tap index 0..4, offset tap-2
    logic       scan_end;  // result closes the scan
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] lo;        // lowest snapshot position that belongs to this scan
    logic       last;      // captured ray is the final one of the scan
    logic       out_busy;  // output register holds a request not yet taken
  } dp_sts_t;

endpackage

// File: src/rshf_dp.sv
// datapath of the range scan hole-fill smoother
// holds config, ray window, tap accumulator, bit-serial divider, output register
// depends on rshf_pkg
module rshf_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rshf_pkg::DistW-1:0] cfg_wdata_i,
  input  logic [rshf_pkg::DistW-1:0] ray_dist_i,
  input  logic                      last_ray_i,
  input  rshf_pkg::dp_cmd_t         cmd_i,
  output rshf_pkg::dp_sts_t         sts_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [rshf_pkg::DistW-1:0] out_dist_o,
  output logic                      out_end_o
);
  import rshf_pkg::*;

  logic [DistW-1:0]   max_q;
  logic [DistW-1:0]   win_q [WinDepth];
  logic [2:0]         seen_q, seen_d;
  logic [DistW-1:0]   snap_q [SnapLen];
  logic [2:0]         lo_q;
  logic               last_q;
  logic [AccW-1:0]    acc_q;
  logic [WsumW-1:0]   wsum_q;
  logic [AccW-1:0]    quo_q;
  logic [WsumW-1:0]   rem_q;
  logic               out_valid_q;
  logic [DistW-1:0]   out_dist_q;
  logic               out_end_q;

  logic [3:0]         pos;
  logic [3:0]         idx_w;
  logic               in_range;
  logic [2:0]         sel;
  logic [DistW-1:0]   tap_dist;
  logic               tap_ok;
  logic [2:0]         weight;
  logic [DistW+2:0]   prod;
  logic [WsumW:0]     trial;
  logic [DistW-1:0]   center_dist;
  logic [DistW-1:0]   result;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxValidRst;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // rays of the current scan, saturating at the window depth
  always_comb begin
    if (last_ray_i) begin
      seen_d = 3'd0;
    end else if (seen_q < 3'(WinDepth)) begin
      seen_d = seen_q + 3'd1;
    end else begin
      seen_d = seen_q;
    end
  end

  // window and count, cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int i = 0; i < WinDepth; i++) win_q[i] <= '0;
    end else if (cmd_i.load) begin
      seen_q <= seen_d;
      for (int i = 0; i < WinDepth - 1; i++) win_q[i] <= win_q[i+1];
      win_q[WinDepth-1] <= ray_dist_i;
    end
  end

  // snapshot: window then new ray, position 4 is the newest
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < WinDepth; i++) snap_q[i] <= win_q[i];
      snap_q[WinDepth] <= ray_dist_i;
      lo_q   <= 3'(WinDepth) - seen_q;
      last_q <= last_ray_i;
    end
  end

  // tap selection with the window clipped at the scan start
  always_comb begin
    pos      = {1'b0, cmd_i.center} + {1'b0, cmd_i.tap};
    idx_w    = pos - 4'd2;
    in_range = (pos >= ({1'b0, lo_q} + 4'd2)) && (pos <= 4'd6);
    sel      = in_range ? idx_w[2:0] : 3'd0;
    tap_dist = snap_q[sel];
    tap_ok   = in_range && (tap_dist <= max_q);
    weight   = tap_weight(cmd_i.tap);
    prod     = 19'(tap_dist) * 19'(weight);
  end

  // weighted sum and weight sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      acc_q  <= '0;
      wsum_q <= '0;
    end else if (cmd_i.tap_en && tap_ok) begin
      acc_q  <= acc_q + AccW'(prod);
      wsum_q <= wsum_q + WsumW'(weight);
    end
  end

  // restoring divider, one quotient bit per step
  assign trial = {rem_q, quo_q[AccW-1]} - {1'b0, wsum_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      quo_q <= acc_q;
      rem_q <= '0;
    end else if (cmd_i.div_en) begin
      if (!trial[WsumW]) begin
        rem_q <= trial[WsumW-1:0];
        quo_q <= {quo_q[AccW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[WsumW-2:0], quo_q[AccW-1]};
        quo_q <= {quo_q[AccW-2:0], 1'b0};
      end
    end
  end

  // valid center or no valid neighbor keeps the raw reading
  always_comb begin
    center_dist = snap_q[cmd_i.center];
    if ((center_dist <= max_q) || (wsum_q == '0)) begin
      result = center_dist;
    end else begin
      result = quo_q[DistW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_dist_q <= result;
      out_end_q  <= cmd_i.scan_end;
    end
  end

  assign sts_o.lo       = lo_q;
  assign sts_o.last     = last_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_dist_o  = out_dist_q;
  assign out_end_o   = out_end_q;

endmodule

// File: src/rshf_ctrl.sv
// controller of the range scan hole-fill smoother
// sequences capture, tap accumulation, division and result push per ray
// depends on rshf_pkg
module rshf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rshf_pkg::dp_sts_t sts_i,
  output rshf_pkg::dp_cmd_t cmd_o
);
  import rshf_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StStart = 6'b000010,
    StTap   = 6'b000100,
    StDinit = 6'b001000,
    StDiv   = 6'b010000,
    StPush  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [2:0]           center_q, center_d;
  logic [2:0]           tap_q, tap_d;
  logic [DivCntW-1:0]   div_q, div_d;
  logic [2:0]           start_center;
  logic                 has_result;

  // first center of this ray, and whether any result is due
  always_comb begin
    has_result   = sts_i.last || (sts_i.lo <= FirstCenter);
    start_center = (sts_i.last && (sts_i.lo > FirstCenter)) ? sts_i.lo : FirstCenter;
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    center_d      = center_q;
    tap_d         = tap_q;
    div_d         = div_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.center  = center_q;
    cmd_o.tap     = tap_q;
    cmd_o.scan_end = sts_i.last && (center_q == LastCenter);
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StStart;
        end
      end
      StStart: begin
        if (has_result) begin
          center_d  = start_center;
          tap_d     = '0;
          cmd_o.clr = 1'b1;
          state_d   = StTap;
        end else begin
          state_d = StIdle;
        end
      end
      StTap: begin
        cmd_o.tap_en = 1'b1;
        if (tap_q == LastTap) begin
          state_d = StDinit;
        end else begin
          tap_d = tap_q + 3'd1;
        end
      end
      StDinit: begin
        cmd_o.div_init = 1'b1;
        div_d          = '0;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_en = 1'b1;
        if (div_q == LastDivStep) begin
          state_d = StPush;
        end else begin
          div_d = div_q + DivCntW'(1);
        end
      end
      StPush: begin
        if (!sts_i.out_busy) begin
          cmd_o.push = 1'b1;
          if (!sts_i.last || (center_q == LastCenter)) begin
            state_d = StIdle;
          end else begin
            center_d  = center_q + 3'd1;
            tap_d     = '0;
            cmd_o.clr = 1'b1;
            state_d   = StTap;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      center_q <= FirstCenter;
      tap_q    <= '0;
      div_q    <= '0;
    end else begin
      state_q  <= state_d;
      center_q <= center_d;
      tap_q    <= tap_d;
      div_q    <= div_d;
    end
  end

endmodule

// File: src/range_scan_hole_fill_smoother.sv
// top level of the range scan hole-fill smoother
// joins rshf_ctrl and rshf_dp; depends on rshf_pkg
//
// Takes one lidar range reading per request in ray order, s_axis_tlast on the
// final ray of a scan. Readings above max_valid_dist are replaced by the 1,4,6,4,1
// weighted mean (truncated) of the valid rays within two positions, clipped at
// the scan ends; valid readings, and holes with no valid neighbor, pass as is.
// Results trail the input by two rays and the last ray flushes the rest, with
// m_axis_tlast on the final result. One ray is worked on at a time: the next
// ray is accepted only once every result of the current ray is pushed, and a
// last ray yields up to three results. Each result runs the tap accumulation,
// then the 20-step bit-serial divider, and then waits for m_axis_tready while
// the output register is still full. A finished result waits in the output
// register while the next ray is accepted. cfg_we_i writes max_valid_dist
// (reset 5000); it must be used only while idle, the block does not enforce it.
module range_scan_hole_fill_smoother (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rshf_pkg::DistW-1:0] cfg_wdata_i,    // max_valid_dist
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [rshf_pkg::DistW-1:0] s_axis_tdata,   // [15:0] ray_dist
  input  logic                       s_axis_tlast,   // last_ray
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [rshf_pkg::DistW-1:0] m_axis_tdata,   // [15:0] smoothed_dist
  output logic                       m_axis_tlast    // scan_end
);
  import rshf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rshf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rshf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ray_dist_i  (s_axis_tdata),
    .last_ray_i  (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_dist_o  (m_axis_tdata),
    .out_end_o   (m_axis_tlast)
  );

endmodule

// File: tb/range_scan_hole_fill_smoother_tb.sv
// self-checking testbench for the range scan hole-fill smoother
// drives ray requests with random gaps and stalls, predicts each smoothed ray in-line
// depends on rshf_pkg and range_scan_hole_fill_smoother
`timescale 1ns / 1ps

module range_scan_hole_fill_smoother_tb;
  import rshf_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned WinSlots = 4;

  typedef struct {
    logic [DistW-1:0] reading;
    logic             last;
  } ray_t;

  typedef struct {
    logic [DistW-1:0] reading;
    logic             scan_end;
  } smoothed_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [DistW-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DistW-1:0] s_axis_tdata = '0;  // [15:0] ray_dist
  logic             s_axis_tlast = 1'b0; // last_ray
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DistW-1:0] m_axis_tdata;       // [15:0] smoothed_dist
  logic             m_axis_tlast;       // scan_end

  // rays waiting to be driven and smoothed rays still to arrive
  ray_t        ray_q[$];
  smoothed_t   smoothed_q[$];

  // shadow of the filter state
  logic [DistW-1:0] limit_model = MaxValidRst;
  logic [DistW-1:0] hist [WinSlots];
  int unsigned      hist_cnt = 0;
  logic [DistW-1:0] snap [WinSlots+1];
  int               snap_cnt;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned rays_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned cycle_count = 0;

  range_scan_hole_fill_smoother DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               smoothed_q.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned binomial_gain(input int k);
    case (k)
      0, 4:    return 1;
      1, 3:    return 4;
      2:       return 6;
      default: return 0;
    endcase
  endfunction

  // smoothed value of snapshot slot c, window clipped to snap_cnt entries
  function automatic logic [DistW-1:0] smooth_slot(input int c);
    logic [31:0] acc;
    logic [31:0] gain_sum;
    int          pos;
    acc = '0;
    gain_sum = '0;
    if (snap[c] <= limit_model) return snap[c];
    for (int d = -2; d <= 2; d++) begin
      pos = c + d;
      if (pos >= 0 && pos < snap_cnt && snap[pos] <= limit_model) begin
        acc += binomial_gain(d + 2) * snap[pos];
        gain_sum += binomial_gain(d + 2);
      end
    end
    if (gain_sum == 0) return snap[c];
    return DistW'(acc / gain_sum);
  endfunction

  // update the shadow state for one accepted ray and queue what it releases
  task automatic predict_ray(input logic [DistW-1:0] reading, input logic last);
    int first;
    smoothed_t res;
    for (int i = 0; i < int'(hist_cnt); i++) snap[i] = hist[WinSlots - hist_cnt + i];
    snap[hist_cnt] = reading;
    snap_cnt = hist_cnt + 1;
    first = snap_cnt - 3;
    if (last) begin
      if (first < 0) first = 0;
      for (int c = first; c < snap_cnt; c++) begin
        res.reading = smooth_slot(c);
        res.scan_end = (c == snap_cnt - 1);
        smoothed_q.push_back(res);
      end
    end else if (first >= 0) begin
      res.reading = smooth_slot(first);
      res.scan_end = 1'b0;
      smoothed_q.push_back(res);
    end
    for (int i = 0; i < WinSlots - 1; i++) hist[i] = hist[i + 1];
    hist[WinSlots - 1] = reading;
    if (last) hist_cnt = 0;
    else if (hist_cnt < WinSlots) hist_cnt++;
  endtask

  // ray driver: presents queued rays with random gaps
  always @(posedge clk_i) begin
    ray_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_ray(s_axis_tdata, s_axis_tlast);
        rays_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (ray_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = ray_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nxt.reading;
          s_axis_tlast <= nxt.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink with random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [DistW-1:0] got,
                                 input logic [DistW-1:0] want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got %0d expected %0d", results_checked, what,
             got, want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    smoothed_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (smoothed_q.size() == 0) begin
        report_mismatch("unexpected request, smoothed_dist", m_axis_tdata, '0);
      end else begin
        want = smoothed_q.pop_front();
        if (m_axis_tdata !== want.reading)
          report_mismatch("smoothed_dist", m_axis_tdata, want.reading);
        if (m_axis_tlast !== want.scan_end)
          report_mismatch("scan_end", DistW'(m_axis_tlast), DistW'(want.scan_end));
      end
      results_checked++;
    end
  end

  // hand one ray to the driver, keep the backlog short
  task automatic send_ray(input logic [DistW-1:0] reading, input logic last);
    ray_t r;
    r.reading = reading;
    r.last = last;
    ray_q.push_back(r);
    while (ray_q.size() > 1) @(posedge clk_i);
  endtask

  // wait until the block has nothing left in flight
  task automatic wait_idle();
    while (ray_q.size() > 0 || s_axis_tvalid || smoothed_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [DistW-1:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_model = value;
  endtask

  // mostly valid rays, a fair share of holes, some boundary and full-range values
  function automatic logic [DistW-1:0] pick_ray(input logic [DistW-1:0] lim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return DistW'($urandom_range(0, lim));
    if (r < 85) begin
      if (lim == '1) return '1;
      return DistW'($urandom_range(int'(lim) + 1, 65535));
    end
    if (r < 90) return lim;
    if (r < 93) return lim + 1'b1;
    return DistW'($urandom());
  endfunction

  // scans at the reset limit: boundary, clipping, short scans, isolated holes
  task automatic test_reset_limit_scans();
    send_ray(16'd5000, 1'b0);
    send_ray(16'd5001, 1'b0);
    send_ray(16'hFFFF, 1'b0);
    send_ray(16'd0, 1'b0);
    send_ray(16'd4999, 1'b1);
    // single hole with nothing around it
    send_ray(16'd6000, 1'b1);
    // two-ray scan ending in a hole
    send_ray(16'd100, 1'b0);
    send_ray(16'd9000, 1'b1);
    // holes only, raw values kept
    repeat (3) send_ray(16'd9000, 1'b0);
    send_ray(16'd9000, 1'b1);
  endtask

  // limit at zero, at full scale and just below full scale
  task automatic test_limit_extremes();
    write_limit(16'd0);
    send_ray(16'd0, 1'b0);
    send_ray(16'd1, 1'b0);
    send_ray(16'd0, 1'b0);
    send_ray(16'hFFFF, 1'b1);
    write_limit(16'hFFFF);
    send_ray(16'hFFFF, 1'b0);
    send_ray(16'd0, 1'b0);
    send_ray(16'hFFFF, 1'b1);
    // largest weighted sum the filter can see
    write_limit(16'hFFFE);
    send_ray(16'hFFFE, 1'b0);
    send_ray(16'hFFFE, 1'b0);
    send_ray(16'hFFFF, 1'b0);
    send_ray(16'hFFFE, 1'b0);
    send_ray(16'hFFFE, 1'b1);
  endtask

  // random scans of random length under one limit and one idling pattern
  task automatic test_random_scans(input int unsigned n_rays, input logic [DistW-1:0] lim,
                                   input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned sent;
    int unsigned len;
    write_limit(lim);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_rays) begin
      len = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 2) : $urandom_range(3, 14);
      for (int unsigned i = 0; i < len; i++) send_ray(pick_ray(lim), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    for (int i = 0; i < WinSlots; i++) hist[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_limit_scans();
    test_limit_extremes();
    test_random_scans(100, DistW'($urandom_range(1000, 60000)), 0, 0);
    test_random_scans(100, DistW'($urandom_range(100, 800)), 64, 0);
    test_random_scans(100, 16'hFFFE, 0, 64);
    test_random_scans(100, DistW'($urandom_range(0, 65535)), 37, 37);

    wait_idle();
    repeat (100) @(posedge clk_i);
    $display("covered %0d rays in directed and random scans under fixed and random limits",
             rays_accepted);
    $display("checked %0d smoothed rays, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0 && smoothed_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
